FILE: src/lswa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light sample window averager package
// Shared widths, reset level, output queue sizing and the result record.
// ----------------------------------------------------------------------------
package lswa_pkg;

    localparam int SAMPLE_W        = 10;
    localparam int DIFF_W          = 11;
    localparam int LEVEL_MAX       = 1023;
    localparam int RESET_LEVEL     = 600;
    localparam int PAST_STEPS      = 5;

    localparam int WINDOW_DEF      = 8;
    localparam int MEANS_DEF       = 4;
    localparam int MEAN_PERIOD_DEF = 4;

    localparam int OFIFO_DEPTH     = 8;
    localparam int OFIFO_PTR_W     = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CNT_W     = $clog2(OFIFO_DEPTH + 1);

    typedef struct packed {
        logic [SAMPLE_W-1:0]      current_level;
        logic signed [DIFF_W-1:0] edge_diff;
        logic signed [DIFF_W-1:0] past_diff;
        logic [SAMPLE_W-1:0]      mean_level;
        logic                     mean_updated;
    } result_t;

    typedef struct packed {
        logic [OFIFO_CNT_W-1:0] count;
        logic                   empty;
    } fifo_status_t;

endpackage

FILE: src/lswa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered and shows the
// old contents when the same entry is written in the same cycle.
// ----------------------------------------------------------------------------
module lswa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/lswa_cdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant divider
// Truncating division by a fixed divisor through one registered
// multiplication by a rounded-up reciprocal; exact over the full input range.
// ----------------------------------------------------------------------------
module lswa_cdiv #(
    parameter int IN_W    = 16,
    parameter int DIVISOR = 8
) (
    input  logic            clk,
    input  logic [IN_W-1:0] dividend,
    output logic [IN_W-1:0] quotient
);

    localparam int LD     = $clog2(DIVISOR);
    localparam int SH     = IN_W + LD;
    localparam int MUL_W  = IN_W + 2;
    localparam int PROD_W = SH + IN_W;
    localparam longint unsigned MUL_VAL = ((longint'(1) << SH) + DIVISOR - 1) / DIVISOR;
    localparam logic [MUL_W-1:0] MUL    = MUL_W'(MUL_VAL);

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    // The rounding error of the reciprocal stays below 1/DIVISOR for every
    // input, so the shifted product is the exact truncated quotient.
    assign prod_next = PROD_W'(dividend) * PROD_W'(MUL);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign quotient = prod_reg[PROD_W-1:SH];

endmodule

FILE: src/lswa_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result queue
// Small register queue between the fixed-latency pipeline and the result
// channel; space is reserved upstream so a write never finds it full.
// ----------------------------------------------------------------------------
module lswa_out_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  lswa_pkg::result_t     wr_data,
    output logic                  rd_valid,
    input  logic                  rd_ready,
    output lswa_pkg::result_t     rd_data,
    output lswa_pkg::fifo_status_t status
);

    lswa_pkg::result_t                  mem_reg [lswa_pkg::OFIFO_DEPTH];
    logic [lswa_pkg::OFIFO_PTR_W-1:0]   wptr_reg;
    logic [lswa_pkg::OFIFO_PTR_W-1:0]   wptr_next;
    logic [lswa_pkg::OFIFO_PTR_W-1:0]   rptr_reg;
    logic [lswa_pkg::OFIFO_PTR_W-1:0]   rptr_next;
    logic [lswa_pkg::OFIFO_CNT_W-1:0]   count_reg;
    logic [lswa_pkg::OFIFO_CNT_W-1:0]   count_next;
    logic                               rd_fire;

    assign rd_valid = (count_reg != '0);
    assign rd_fire  = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (wr_en)
        begin
            wptr_next = (wptr_reg == lswa_pkg::OFIFO_PTR_W'(lswa_pkg::OFIFO_DEPTH - 1))
                        ? '0 : wptr_reg + 1'b1;
        end
        if (rd_fire)
        begin
            rptr_next = (rptr_reg == lswa_pkg::OFIFO_PTR_W'(lswa_pkg::OFIFO_DEPTH - 1))
                        ? '0 : rptr_reg + 1'b1;
        end
        if (wr_en && !rd_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    assign status.count = count_reg;
    assign status.empty = !rd_valid;

endmodule

FILE: src/light_sample_window_averager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light sample window averager
// Windowed running sum of light samples with a decimated history of block
// means; every sample yields one result with edge and past differences.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | transfer when
//  ---------+-------------------------------------------+----------------------------
//  input    | sample, sample_valid, sample_ready        | sample_valid && sample_ready
//  result   | current_level .. mean_updated,            | result_valid && result_ready
//           | result_valid, result_ready                |
//  config   | cfg_we, cfg_wdata (gray level)            | cfg_we
//
// One sample per cycle is sustained while the queue has room. A result enters
// the 8-entry output queue after three registered stages: window RAM read, block
// mean multiply with history RAM read, history mean multiply.
// sample_ready falls when queued results plus samples in those three stages
// fill the queue. No clearing pass after reset: fill pointers make unwritten
// window and history entries read as 600.
// ----------------------------------------------------------------------------
module light_sample_window_averager #(
    parameter int WINDOW      = lswa_pkg::WINDOW_DEF,
    parameter int MEANS       = lswa_pkg::MEANS_DEF,
    parameter int MEAN_PERIOD = lswa_pkg::MEAN_PERIOD_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lswa_pkg::SAMPLE_W-1:0]        cfg_wdata,
    input  logic [lswa_pkg::SAMPLE_W-1:0]        sample,
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    output logic [lswa_pkg::SAMPLE_W-1:0]        current_level,
    output logic signed [lswa_pkg::DIFF_W-1:0]   edge_diff,
    output logic signed [lswa_pkg::DIFF_W-1:0]   past_diff,
    output logic [lswa_pkg::SAMPLE_W-1:0]        mean_level,
    output logic                                 mean_updated,
    output logic                                 result_valid,
    input  logic                                 result_ready
);

    localparam int SW     = lswa_pkg::SAMPLE_W;
    localparam int DW     = lswa_pkg::DIFF_W;
    localparam int PS     = lswa_pkg::PAST_STEPS;
    localparam int WA_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int HA_W   = (MEANS > 1) ? $clog2(MEANS) : 1;
    localparam int PC_W   = (MEAN_PERIOD > 1) ? $clog2(MEAN_PERIOD) : 1;
    localparam int WSUM_W = $clog2(WINDOW * lswa_pkg::LEVEL_MAX + 1);
    localparam int HSUM_W = $clog2(MEANS * lswa_pkg::LEVEL_MAX + 1);
    localparam int OCNT_W = lswa_pkg::OFIFO_CNT_W + 1;

    localparam logic [SW-1:0]     LEVEL_RST = SW'(lswa_pkg::RESET_LEVEL);
    localparam logic [WSUM_W-1:0] WSUM_RST  = WSUM_W'(WINDOW * lswa_pkg::RESET_LEVEL);
    localparam logic [HSUM_W-1:0] HSUM_RST  = HSUM_W'(MEANS * lswa_pkg::RESET_LEVEL);
    localparam logic [WSUM_W-1:0] WSUM_MAX  = WSUM_W'(WINDOW * lswa_pkg::LEVEL_MAX);
    localparam logic [HSUM_W-1:0] HSUM_MAX  = HSUM_W'(MEANS * lswa_pkg::LEVEL_MAX);

    // Configuration and intake state
    logic [SW-1:0]   gray_level_reg;
    logic [WA_W-1:0] wptr_reg;
    logic            wwrap_reg;
    logic [PC_W-1:0] pcnt_reg;
    logic [SW-1:0]   past_line_reg [PS];
    logic            in_fire;
    logic            push0;

    // Stage 1: window read data returns
    logic            v1_reg;
    logic            push1_reg;
    logic            oldv1_reg;
    logic [SW-1:0]   s1_reg;
    logic [SW-1:0]   past1_reg;
    logic [SW-1:0]   win_rdata;
    logic [SW-1:0]   old_sample;
    logic [WSUM_W-1:0] wsum_reg;
    logic [WSUM_W-1:0] wsum_next;
    logic [DW-1:0]   edge1;
    logic [DW-1:0]   pdiff1;
    logic [HA_W-1:0] hptr_reg;
    logic            hwrap_reg;

    // Stage 2: block mean ready, history read data returns
    logic            v2_reg;
    logic            push2_reg;
    logic [SW-1:0]   s2_reg;
    logic [DW-1:0]   edge2_reg;
    logic [DW-1:0]   pdiff2_reg;
    logic [HA_W-1:0] haddr2_reg;
    logic            hvalid2_reg;
    logic            fwd2_reg;
    logic [SW-1:0]   fwd_data2_reg;
    logic [WSUM_W-1:0] wdiv_q;
    logic [SW-1:0]   block_mean;
    logic [SW-1:0]   hist_rdata;
    logic [SW-1:0]   head_mean;
    logic            hist_we;
    logic [HSUM_W-1:0] hsum_reg;
    logic [HSUM_W-1:0] hsum_next;

    // Stage 3: history mean ready
    logic            v3_reg;
    logic            push3_reg;
    logic [SW-1:0]   s3_reg;
    logic [DW-1:0]   edge3_reg;
    logic [DW-1:0]   pdiff3_reg;
    logic [HSUM_W-1:0] hdiv_q;

    lswa_pkg::result_t      res3;
    lswa_pkg::result_t      out_res;
    lswa_pkg::fifo_status_t fifo_stat;
    logic [OCNT_W-1:0]      in_flight;

    // ------------------------------------------------------------------------
    // Intake
    // ------------------------------------------------------------------------
    assign in_flight    = OCNT_W'(fifo_stat.count) + OCNT_W'(v1_reg)
                        + OCNT_W'(v2_reg) + OCNT_W'(v3_reg);
    assign sample_ready = (in_flight < OCNT_W'(lswa_pkg::OFIFO_DEPTH));
    assign in_fire      = sample_valid && sample_ready;
    assign push0        = (pcnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_level_reg <= LEVEL_RST;
            wptr_reg       <= '0;
            wwrap_reg      <= 1'b0;
            pcnt_reg       <= '0;
            past_line_reg  <= '{default: LEVEL_RST};
        end
        else
        begin
            if (cfg_we)
            begin
                gray_level_reg <= cfg_wdata;
            end
            if (in_fire)
            begin
                wptr_reg <= (wptr_reg == WA_W'(WINDOW - 1)) ? '0 : wptr_reg + 1'b1;
                if (wptr_reg == WA_W'(WINDOW - 1))
                begin
                    wwrap_reg <= 1'b1;
                end
                pcnt_reg <= (pcnt_reg == PC_W'(MEAN_PERIOD - 1)) ? '0 : pcnt_reg + 1'b1;
                past_line_reg[0] <= sample;
                for (int i = 1; i < PS; i++)
                begin
                    past_line_reg[i] <= past_line_reg[i-1];
                end
            end
        end
    end

    // The oldest window entry is read and replaced by the new sample at the
    // same edge; the RAM returns the old contents.
    lswa_ram #(
        .WIDTH (SW),
        .DEPTH (WINDOW),
        .AW    (WA_W)
    ) u_window_ram (
        .clk   (clk),
        .we    (in_fire),
        .waddr (wptr_reg),
        .wdata (sample),
        .raddr (wptr_reg),
        .rdata (win_rdata)
    );

    // ------------------------------------------------------------------------
    // Stage 1: running window sum
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        s1_reg    <= sample;
        past1_reg <= past_line_reg[PS-1];
        oldv1_reg <= wwrap_reg;
        push1_reg <= push0;
    end

    assign old_sample = oldv1_reg ? win_rdata : LEVEL_RST;
    assign wsum_next  = wsum_reg - WSUM_W'(old_sample) + WSUM_W'(s1_reg);
    assign edge1      = DW'(gray_level_reg) - DW'(s1_reg);
    assign pdiff1     = DW'(past1_reg) - DW'(s1_reg);

    lswa_cdiv #(
        .IN_W    (WSUM_W),
        .DIVISOR (WINDOW)
    ) u_window_div (
        .clk      (clk),
        .dividend (wsum_next),
        .quotient (wdiv_q)
    );

    // ------------------------------------------------------------------------
    // Stage 2: push the block mean into the history
    // ------------------------------------------------------------------------
    assign block_mean = wdiv_q[SW-1:0];
    assign hist_we    = v2_reg && push2_reg;
    assign head_mean  = fwd2_reg    ? fwd_data2_reg :
                        hvalid2_reg ? hist_rdata    : LEVEL_RST;
    assign hsum_next  = hist_we ? (hsum_reg - HSUM_W'(head_mean) + HSUM_W'(block_mean))
                                : hsum_reg;

    // A push leaving stage 2 writes the entry that a push entering stage 2
    // has just read when the history has a single entry; that value is
    // forwarded.
    always_ff @(posedge clk)
    begin
        s2_reg        <= s1_reg;
        edge2_reg     <= edge1;
        pdiff2_reg    <= pdiff1;
        push2_reg     <= push1_reg;
        haddr2_reg    <= hptr_reg;
        hvalid2_reg   <= hwrap_reg;
        fwd_data2_reg <= block_mean;
    end

    lswa_ram #(
        .WIDTH (SW),
        .DEPTH (MEANS),
        .AW    (HA_W)
    ) u_history_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (haddr2_reg),
        .wdata (block_mean),
        .raddr (hptr_reg),
        .rdata (hist_rdata)
    );

    lswa_cdiv #(
        .IN_W    (HSUM_W),
        .DIVISOR (MEANS)
    ) u_history_div (
        .clk      (clk),
        .dividend (hsum_next),
        .quotient (hdiv_q)
    );

    // ------------------------------------------------------------------------
    // Stage 3 and control
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        s3_reg     <= s2_reg;
        edge3_reg  <= edge2_reg;
        pdiff3_reg <= pdiff2_reg;
        push3_reg  <= push2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            fwd2_reg  <= 1'b0;
            hptr_reg  <= '0;
            hwrap_reg <= 1'b0;
            wsum_reg  <= WSUM_RST;
            hsum_reg  <= HSUM_RST;
        end
        else
        begin
            v1_reg   <= in_fire;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            fwd2_reg <= v1_reg && push1_reg && hist_we && (haddr2_reg == hptr_reg);
            if (v1_reg)
            begin
                wsum_reg <= wsum_next;
            end
            if (v1_reg && push1_reg)
            begin
                hptr_reg <= (hptr_reg == HA_W'(MEANS - 1)) ? '0 : hptr_reg + 1'b1;
                if (hptr_reg == HA_W'(MEANS - 1))
                begin
                    hwrap_reg <= 1'b1;
                end
            end
            hsum_reg <= hsum_next;
        end
    end

    assign res3.current_level = s3_reg;
    assign res3.edge_diff     = edge3_reg;
    assign res3.past_diff     = pdiff3_reg;
    assign res3.mean_level    = hdiv_q[SW-1:0];
    assign res3.mean_updated  = push3_reg;

    lswa_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (v3_reg),
        .wr_data  (res3),
        .rd_valid (result_valid),
        .rd_ready (result_ready),
        .rd_data  (out_res),
        .status   (fifo_stat)
    );

    assign current_level = out_res.current_level;
    assign edge_diff     = out_res.edge_diff;
    assign past_diff     = out_res.past_diff;
    assign mean_level    = out_res.mean_level;
    assign mean_updated  = out_res.mean_updated;

`ifndef NO_ASSERTIONS
    // Reserved queue space must cover every sample still in the pipeline.
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        in_flight <= OCNT_W'(lswa_pkg::OFIFO_DEPTH))
        else $error("result queue overcommitted");

    a_wsum_range: assert property (@(posedge clk) disable iff (!rst_n)
        wsum_reg <= WSUM_MAX)
        else $error("window sum out of range");

    a_hsum_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsum_reg <= HSUM_MAX)
        else $error("history sum out of range");

    a_fwd_push: assert property (@(posedge clk) disable iff (!rst_n)
        fwd2_reg |-> (v2_reg && push2_reg))
        else $error("history forward without a push");
`endif

endmodule
